FILE: sv/tws_pkg.sv
`default_nettype none

package tws_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int COUNT_W       = $clog2(NODE_COUNT + 1);
    localparam int LIDX_W        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int LETTER_W      = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_command;

    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MREAD,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic mark_rd;
        logic finish;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic item_ends;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: sv/tws_ctrl.sv
`default_nettype none

module tws_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire tws_pkg::t_dp_stat  i_stat,
    output tws_pkg::t_dp_cmd        o_cmd
);

    tws_pkg::t_state r_state;
    tws_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tws_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tws_pkg::S_CLEAR: begin
                if (i_stat.clr_done) n_state = tws_pkg::S_IDLE;
            end
            tws_pkg::S_IDLE: begin
                if (i_valid) n_state = tws_pkg::S_EXEC;
            end
            tws_pkg::S_EXEC: begin
                if (i_stat.item_ends) begin
                    n_state = tws_pkg::S_MREAD;
                end else begin
                    n_state = tws_pkg::S_IDLE;
                end
            end
            tws_pkg::S_MREAD: begin
                n_state = tws_pkg::S_FINISH;
            end
            tws_pkg::S_FINISH: begin
                if (i_stat.out_free) n_state = tws_pkg::S_IDLE;
            end
            default: begin
                n_state = tws_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            tws_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            tws_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            tws_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            tws_pkg::S_MREAD: begin
                o_cmd.mark_rd = 1'b1;
            end
            tws_pkg::S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/tws_dp.sv
`default_nettype none

module tws_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tws_pkg::t_dp_cmd              i_cmd,
    output tws_pkg::t_dp_stat                  o_stat,
    input  wire logic                          i_command,
    input  wire logic [tws_pkg::LETTER_W-1:0]  i_letter,
    input  wire logic                          i_last_letter,
    input  wire logic                          i_empty_word,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_found,
    output logic                               o_status
);

    tws_pkg::t_row row_mem [tws_pkg::NODE_COUNT];
    logic          mark_mem [tws_pkg::NODE_COUNT];

    tws_pkg::t_command                r_cmd;
    logic [tws_pkg::LETTER_W-1:0]     r_letter;
    logic                             r_last;
    logic                             r_empty;
    tws_pkg::t_row                    r_row;
    logic                             r_mark;

    logic [tws_pkg::NODE_W-1:0]       r_cur;
    logic [tws_pkg::COUNT_W-1:0]      r_used;
    logic                             r_missed;
    logic                             r_full;
    logic [tws_pkg::NODE_W-1:0]       r_clr_addr;

    logic                             r_out_valid;
    logic                             r_found;
    logic                             r_status;

    logic [tws_pkg::LIDX_W-1:0]       sel;
    logic                             in_range;
    logic [tws_pkg::NODE_W-1:0]       child;
    logic                             walk;
    logic                             do_alloc;
    logic                             pool_full;
    logic                             word_ok;
    logic                             is_insert;
    tws_pkg::t_row                    new_row;
    logic                             row_we;
    logic [tws_pkg::NODE_W-1:0]       row_waddr;
    tws_pkg::t_row                    row_wdata;
    logic                             mark_we;
    logic [tws_pkg::NODE_W-1:0]       mark_waddr;
    logic                             mark_wdata;

    assign sel       = tws_pkg::LIDX_W'(r_letter);
    assign in_range  = (32'(r_letter) < tws_pkg::ALPHABET_SIZE);
    assign child     = r_row[sel];
    assign walk      = !r_empty && !r_missed && !r_full;
    assign pool_full = (r_used >= tws_pkg::COUNT_W'(tws_pkg::NODE_COUNT));
    assign is_insert = (r_cmd == tws_pkg::CMD_INSERT);
    assign do_alloc  = i_cmd.exec && walk && in_range && (child == '0) && is_insert
                       && !pool_full;
    assign word_ok   = !r_missed && !r_full;

    always_comb begin
        new_row      = r_row;
        new_row[sel] = r_used[tws_pkg::NODE_W-1:0];
    end

    always_comb begin
        row_we     = 1'b0;
        row_waddr  = r_cur;
        row_wdata  = new_row;
        mark_we    = 1'b0;
        mark_waddr = r_cur;
        mark_wdata = 1'b1;
        if (i_cmd.clear) begin
            row_we     = 1'b1;
            row_waddr  = r_clr_addr;
            row_wdata  = '0;
            mark_we    = 1'b1;
            mark_waddr = r_clr_addr;
            mark_wdata = 1'b0;
        end else begin
            row_we  = do_alloc;
            mark_we = i_cmd.finish && is_insert && word_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) row_mem[row_waddr] <= row_wdata;
        if (i_cmd.accept) r_row <= row_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
        if (i_cmd.mark_rd) r_mark <= mark_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= tws_pkg::t_command'(i_command);
            r_letter <= i_letter;
            r_last   <= i_last_letter;
            r_empty  <= i_empty_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_used     <= tws_pkg::COUNT_W'(1);
            r_missed   <= 1'b0;
            r_full     <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + tws_pkg::NODE_W'(1);
            end
            if (i_cmd.exec && walk) begin
                if (!in_range) begin
                    r_missed <= 1'b1;
                end else if (child != '0) begin
                    r_cur <= child;
                end else if (!is_insert) begin
                    r_missed <= 1'b1;
                end else if (pool_full) begin
                    r_full <= 1'b1;
                end else begin
                    r_cur  <= r_used[tws_pkg::NODE_W-1:0];
                    r_used <= r_used + tws_pkg::COUNT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_cur    <= '0;
                r_missed <= 1'b0;
                r_full   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found  <= is_insert ? word_ok : (word_ok && r_mark);
            r_status <= r_full;
        end
    end

    assign o_stat.clr_done  = (r_clr_addr == tws_pkg::NODE_W'(tws_pkg::NODE_COUNT - 1));
    assign o_stat.item_ends = r_empty || r_last;
    assign o_stat.out_free  = !r_out_valid || !i_stall;

    assign o_valid  = r_out_valid;
    assign o_found  = r_found;
    assign o_status = r_status;

endmodule

`default_nettype wire

FILE: sv/trie_word_insert_search.sv
`default_nettype none

// Channel   Direction  Handshake          Fields
// input     in         i_valid / o_stall  i_command, i_letter, i_last_letter, i_empty_word
// output    out        o_valid / i_stall  o_found, o_status
//
// An item that does not end the word passes through S_IDLE and S_EXEC: the link row of the
// current node is read from the single-port link memory, then the step and any node allocation
// are done. An item that ends the word also passes through S_MREAD and S_FINISH, since the end
// mark of the reached node is read after the step, and it waits in S_FINISH while the result
// register has not drained. After reset a clearing pass over all NODE_COUNT (1024) entries
// zeroes both memories; the input is stalled until it completes. The result register holds a
// finished result while the next word is accepted.

module trie_word_insert_search (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_command,
    input  wire logic [tws_pkg::LETTER_W-1:0]  i_letter,
    input  wire logic                          i_last_letter,
    input  wire logic                          i_empty_word,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_found,
    output logic                               o_status
);

    tws_pkg::t_dp_cmd  dp_cmd;
    tws_pkg::t_dp_stat dp_stat;

    tws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    tws_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .i_empty_word  (i_empty_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LETTER_MAX  = (1 << tws_pkg::LETTER_W) - 1;
    localparam int LTR_A       = 0;
    localparam int LTR_Z       = tws_pkg::ALPHABET_SIZE - 1;
    localparam int TERM_MAX    = 16;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        PH_SLOW_SINK,
        PH_SLOW_SOURCE,
        PH_FREE,
        PH_HOLD
    } t_phase;

    typedef enum logic {
        END_LAST,
        END_EMPTY
    } t_term_end;

    typedef struct packed {
        tws_pkg::t_command              cmd;
        logic [tws_pkg::LETTER_W-1:0]   ltr;
        logic                           last;
        logic                           empty;
    } t_letter_word;

    typedef struct packed {
        logic [4:0]                                   len;
        logic [TERM_MAX-1:0][tws_pkg::LETTER_W-1:0]   ltr;
    } t_term;

    typedef struct packed {
        logic found;
        logic status;
    } t_trie_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic                           i_command = 1'b0;
    logic [tws_pkg::LETTER_W-1:0]   i_letter = '0;
    logic                           i_last_letter = 1'b0;
    logic                           i_empty_word = 1'b0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic                           o_found;
    logic                           o_status;

    trie_word_insert_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .i_empty_word  (i_empty_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_status      (o_status)
    );

    t_letter_word  letter_words[$];
    t_trie_result  expected_answers[$];
    t_term         term_book[$];
    t_phase        phase = PH_SLOW_SINK;
    int            items_pushed = 0;
    int            error_count = 0;
    int            cycle_count = 0;
    int            hold_left = 0;
    bit            hold_taken = 1'b0;
    bit            word_taken = 1'b0;

    int unsigned   link_tab [tws_pkg::NODE_COUNT*tws_pkg::ALPHABET_SIZE];
    bit            end_mark [tws_pkg::NODE_COUNT];
    int            nodes_taken = 1;
    int            walk_node = 0;
    bit            walk_missed = 1'b0;
    bit            walk_full = 1'b0;

    function automatic bit walk_trie(input tws_pkg::t_command cmd,
                                     input logic [tws_pkg::LETTER_W-1:0] ltr,
                                     input logic last, input logic empty,
                                     output logic found, output logic status);
        int  slot;
        int  nxt;
        bit  ok;
        found  = 1'b0;
        status = 1'b0;
        if (!empty && !walk_missed && !walk_full) begin
            if (int'(ltr) >= tws_pkg::ALPHABET_SIZE || walk_node >= tws_pkg::NODE_COUNT) begin
                walk_missed = 1'b1;
            end else begin
                slot = walk_node * tws_pkg::ALPHABET_SIZE + int'(ltr);
                nxt  = int'(link_tab[slot]);
                if (nxt == 0) begin
                    if (cmd == tws_pkg::CMD_SEARCH) begin
                        walk_missed = 1'b1;
                    end else if (nodes_taken >= tws_pkg::NODE_COUNT) begin
                        walk_full = 1'b1;
                    end else begin
                        nxt = nodes_taken;
                        nodes_taken++;
                        link_tab[slot] = 32'(nxt);
                    end
                end
                if (!walk_missed && !walk_full) begin
                    walk_node = nxt;
                end
            end
        end
        if (!empty && !last) begin
            return 1'b0;
        end
        ok = !walk_missed && !walk_full && walk_node < tws_pkg::NODE_COUNT;
        if (cmd == tws_pkg::CMD_INSERT) begin
            if (ok) begin
                end_mark[walk_node] = 1'b1;
                found = 1'b1;
            end
        end else if (ok) begin
            found = end_mark[walk_node];
        end
        status      = walk_full;
        walk_node   = 0;
        walk_missed = 1'b0;
        walk_full   = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_term rand_term(input int lo, input int hi);
        t_term tm;
        bit    narrow;
        tm     = '0;
        tm.len = 5'($urandom_range(hi, lo));
        narrow = 1'($urandom_range(1));
        for (int i = 0; i < hi; i++) begin
            tm.ltr[i] = tws_pkg::LETTER_W'(narrow ? $urandom_range(3)
                                                  : $urandom_range(tws_pkg::ALPHABET_SIZE - 1));
        end
        return tm;
    endfunction

    function automatic t_term term_of(input int n, input int l0, input int l1);
        t_term tm;
        tm        = '0;
        tm.len    = 5'(n);
        tm.ltr[0] = tws_pkg::LETTER_W'(l0);
        tm.ltr[1] = tws_pkg::LETTER_W'(l1);
        return tm;
    endfunction

    task automatic push_item(input tws_pkg::t_command cmd,
                             input logic [tws_pkg::LETTER_W-1:0] ltr,
                             input logic last, input logic empty);
        letter_words.push_back('{cmd: cmd, ltr: ltr, last: last, empty: empty});
        items_pushed++;
    endtask

    task automatic push_term(input tws_pkg::t_command cmd, input t_term tm,
                             input t_term_end ending, input bit mixed);
        tws_pkg::t_command step_cmd;
        bit                ends_here;
        for (int i = 0; i < int'(tm.len); i++) begin
            ends_here = (ending == END_LAST) && (i == int'(tm.len) - 1);
            step_cmd  = cmd;
            if (mixed && !ends_here && $urandom_range(1)) begin
                step_cmd = (cmd == tws_pkg::CMD_INSERT) ? tws_pkg::CMD_SEARCH
                                                        : tws_pkg::CMD_INSERT;
            end
            push_item(step_cmd, tm.ltr[i], ends_here, 1'b0);
        end
        if (ending == END_EMPTY) begin
            push_item(cmd, tws_pkg::LETTER_W'($urandom_range(LETTER_MAX)),
                      1'($urandom_range(1)), 1'b1);
        end
    endtask

    task automatic push_random_term();
        t_term             tm;
        tws_pkg::t_command cmd;
        int                roll;
        roll = (term_book.size() == 0) ? 0 : int'($urandom_range(99));
        cmd  = $urandom_range(1) ? tws_pkg::CMD_SEARCH : tws_pkg::CMD_INSERT;
        if (roll < 35) begin
            tm = rand_term(1, 8);
            push_term(tws_pkg::CMD_INSERT, tm, END_LAST, 1'b0);
            term_book.push_back(tm);
        end else if (roll < 60) begin
            tm = term_book[$urandom_range(term_book.size() - 1)];
            push_term(tws_pkg::CMD_SEARCH, tm, END_LAST, 1'b0);
        end else if (roll < 70) begin
            tm = term_book[$urandom_range(term_book.size() - 1)];
            if (int'(tm.len) > 1 && $urandom_range(1)) begin
                tm.len = tm.len - 5'd1;
            end else if (int'(tm.len) < TERM_MAX - 1) begin
                tm.ltr[tm.len] = tws_pkg::LETTER_W'($urandom_range(tws_pkg::ALPHABET_SIZE - 1));
                tm.len         = tm.len + 5'd1;
            end
            push_term(cmd, tm, END_LAST, 1'b0);
        end else if (roll < 78) begin
            push_term(tws_pkg::CMD_SEARCH, rand_term(1, 8), END_LAST, 1'b0);
        end else if (roll < 85) begin
            push_term(cmd, rand_term(0, 3), END_EMPTY, 1'b0);
        end else if (roll < 91) begin
            tm = rand_term(1, 5);
            tm.ltr[$urandom_range(int'(tm.len) - 1)] =
                tws_pkg::LETTER_W'($urandom_range(LETTER_MAX, tws_pkg::ALPHABET_SIZE));
            push_term(cmd, tm, END_LAST, 1'b0);
        end else begin
            push_term(cmd, rand_term(1, 6), ($urandom_range(3) == 0) ? END_EMPTY : END_LAST,
                      1'b1);
        end
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (letter_words.size() != 0 || i_valid || expected_answers.size() != 0);
    endtask

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        t_letter_word nxt;
        int           idle_pct;
        idle_pct = (phase == PH_SLOW_SINK) ? 9 : (phase == PH_SLOW_SOURCE) ? 80 : 0;
        if (i_rst_n && (!i_valid || word_taken)) begin
            if (letter_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = letter_words.pop_front();
                i_valid       <= 1'b1;
                i_command     <= nxt.cmd;
                i_letter      <= nxt.ltr;
                i_last_letter <= nxt.last;
                i_empty_word  <= nxt.empty;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (phase == PH_SLOW_SINK) ? 80 : (phase == PH_SLOW_SOURCE) ? 9 : 0;
        if (phase == PH_HOLD && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic         fnd;
        logic         sts;
        t_trie_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                $error("o_found: expected no result, got %0d (o_status %0d)", o_found, o_status);
                error_count++;
            end else begin
                exp_r = expected_answers.pop_front();
                if (o_found !== exp_r.found) begin
                    $error("o_found: expected %0d, got %0d", exp_r.found, o_found);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("o_status: expected %0d, got %0d", exp_r.status, o_status);
                    error_count++;
                end
            end
        end
        word_taken = i_rst_n && i_valid && !o_stall;
        if (word_taken && walk_trie(tws_pkg::t_command'(i_command), i_letter, i_last_letter,
                                    i_empty_word, fnd, sts)) begin
            expected_answers.push_back('{found: fnd, status: sts});
        end
    end

    initial begin
        int fill_len;
        int hold_base;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The empty word reaches the root, and a word walk stops at its first miss.
        push_item(tws_pkg::CMD_SEARCH, tws_pkg::LETTER_W'(LETTER_MAX), 1'b1, 1'b1);
        push_item(tws_pkg::CMD_INSERT, tws_pkg::LETTER_W'(0), 1'b0, 1'b1);
        push_item(tws_pkg::CMD_SEARCH, tws_pkg::LETTER_W'(9), 1'b0, 1'b1);
        push_term(tws_pkg::CMD_INSERT, term_of(1, LTR_Z, 0), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_INSERT, term_of(2, LTR_A, LTR_Z), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_SEARCH, term_of(1, LTR_Z, 0), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_SEARCH, term_of(1, LTR_A, 0), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_SEARCH, term_of(2, LTR_A, LTR_Z), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_SEARCH, term_of(1, 1, 0), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_INSERT, term_of(1, LETTER_MAX, 0), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_SEARCH, term_of(2, 2, tws_pkg::ALPHABET_SIZE), END_LAST, 1'b0);
        push_term(tws_pkg::CMD_INSERT, term_of(2, tws_pkg::ALPHABET_SIZE, LTR_A), END_LAST,
                  1'b0);
        push_term(tws_pkg::CMD_INSERT, term_of(1, 1, 0), END_EMPTY, 1'b0);
        push_term(tws_pkg::CMD_SEARCH, term_of(1, 1, 0), END_LAST, 1'b0);
        push_item(tws_pkg::CMD_SEARCH, tws_pkg::LETTER_W'(2), 1'b0, 1'b0);
        push_item(tws_pkg::CMD_INSERT, tws_pkg::LETTER_W'(2), 1'b1, 1'b0);
        push_item(tws_pkg::CMD_INSERT, tws_pkg::LETTER_W'(3), 1'b0, 1'b0);
        push_item(tws_pkg::CMD_SEARCH, tws_pkg::LETTER_W'(3), 1'b1, 1'b0);

        while (items_pushed < 470) begin
            push_random_term();
        end
        drain();

        phase = PH_SLOW_SOURCE;
        while (items_pushed < 920) begin
            push_random_term();
        end
        drain();

        // Long insert words are pushed until the node pool runs dry.
        phase = PH_FREE;
        while (nodes_taken < tws_pkg::NODE_COUNT) begin
            fill_len = tws_pkg::NODE_COUNT - nodes_taken + 2;
            for (int i = 0; i < fill_len; i++) begin
                push_item(tws_pkg::CMD_INSERT,
                          tws_pkg::LETTER_W'($urandom_range(tws_pkg::ALPHABET_SIZE - 1)),
                          i == fill_len - 1, 1'b0);
            end
            drain();
        end

        phase     = PH_HOLD;
        hold_base = items_pushed;
        while (items_pushed < hold_base + 320) begin
            push_random_term();
        end
        drain();

        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
